// ===== sv/button_click_classifier_assert.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define BCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bcc assertion failed");

// next-cycle implication
`define BCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bcc assertion failed");

`endif

// ===== sv/bcc_pkg.sv =====
// types and constants for the button click classifier
// no dependencies
package bcc_pkg;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned EVT_W  = 3;
    localparam int unsigned IDX_W  = 3;

    localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [TICK_W-1:0] HOLD_RST     = 16'd1000;
    localparam logic [TICK_W-1:0] CLICK_RST    = 16'd200;
    localparam logic [TICK_W-1:0] GAP_RST      = 16'd100;
    localparam logic              REL_LVL_RST  = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_HOLD     = 3'd1,
        CFG_CLICK    = 3'd2,
        CFG_GAP      = 3'd3,
        CFG_REL_LVL  = 3'd4
    } t_cfg_idx;

    typedef enum logic [EVT_W-1:0] {
        EV_NONE   = 3'd0,
        EV_SINGLE = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_LSTART = 3'd3,
        EV_LEND   = 3'd4
    } t_event;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] hold_ticks;
        logic [TICK_W-1:0] click_ticks;
        logic [TICK_W-1:0] double_gap_ticks;
        logic              released_level;
    } t_cfg;

endpackage

// ===== sv/button_click_classifier.sv =====
// button click classifier: one sampled pin level in, one event code out per beat
// Use: each input beat carries the pin level sampled at one millisecond tick.
// A level change restarts the debounce count; once the level has been stable
// past debounce_ticks the classifier reports single click, double click,
// long press start and long press end. Every input beat yields exactly one
// output beat, event code 0 when nothing happened.
// Channels: input i_in_valid / o_in_ready with i_button_level; output
// o_out_valid / i_out_ready with o_event_code. Configuration goes through
// i_cfg_wr_en / i_cfg_idx / i_cfg_wdata, written only while the block is idle, a
// rule for the user that the block itself does not enforce. An accepted beat is held
// in the input register, then its event code in the result register. Throughput:
// one beat per cycle while the output is taken, set by these two registers.
// Reset: synchronous, active low; the registers return to their defaults,
// the machine goes idle and both stages empty.
// Stall: a held output keeps its event code; the input register still takes
// one more beat, then o_in_ready drops until the output is taken.
module button_click_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_button_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_code,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);
    import bcc_pkg::*;

    t_cfg   cfg;
    t_event ev;
    logic   r_in_valid;
    logic   r_in_level;
    logic   r_out_valid;
    t_event r_out_event;
    logic   out_free;
    logic   step;
    logic   in_fire;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    bcc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bcc_classifier u_cls (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_level (r_in_level),
        .o_event (ev)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_level <= i_button_level;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_event <= ev;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_out_event;

endmodule

// ===== sv/bcc_cfg_regs.sv =====
// configuration register file of the button click classifier
// depends on bcc_pkg
module bcc_cfg_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [2:0]               i_cfg_idx,
    input  logic [15:0]              i_cfg_wdata,
    output bcc_pkg::t_cfg            o_cfg
);
    import bcc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE: n_cfg.debounce_ticks   = i_cfg_wdata;
                CFG_HOLD:     n_cfg.hold_ticks       = i_cfg_wdata;
                CFG_CLICK:    n_cfg.click_ticks      = i_cfg_wdata;
                CFG_GAP:      n_cfg.double_gap_ticks = i_cfg_wdata;
                CFG_REL_LVL:  n_cfg.released_level   = i_cfg_wdata[0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= DEBOUNCE_RST;
            r_cfg.hold_ticks       <= HOLD_RST;
            r_cfg.click_ticks      <= CLICK_RST;
            r_cfg.double_gap_ticks <= GAP_RST;
            r_cfg.released_level   <= REL_LVL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/bcc_classifier.sv =====
// debounce counter and click state machine, one tick per step
// depends on bcc_pkg
module bcc_classifier (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bcc_pkg::t_cfg            i_cfg,
    input  logic                     i_step,
    input  logic                     i_level,
    output bcc_pkg::t_event          o_event
);
    import bcc_pkg::*;

    typedef enum logic [8:0] {
        M_IDLE   = 9'b000000001,
        M_PRESS  = 9'b000000010,
        M_LSTART = 9'b000000100,
        M_LHELD  = 9'b000001000,
        M_REL    = 9'b000010000,
        M_REPORT = 9'b000100000,
        M_GAP    = 9'b001000000,
        M_PRESS2 = 9'b010000000,
        M_DOUBLE = 9'b100000000
    } t_mode;

    t_mode             r_mode, n_mode;
    logic              r_last, n_last;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [TICK_W-1:0] r_down, n_down;
    logic [TICK_W-1:0] tick_mid;
    logic              released;
    t_event            ev;

    assign released = (i_level == i_cfg.released_level);

    always_comb begin
        n_mode   = r_mode;
        n_last   = r_last;
        n_down   = r_down;
        tick_mid = r_tick;
        ev       = EV_NONE;
        if (i_level != r_last) begin
            n_last   = i_level;
            tick_mid = TICK_W'(1);
        end else if (r_tick > i_cfg.debounce_ticks) begin
            case (r_mode)
                M_IDLE: begin
                    if (!released) n_mode = M_PRESS;
                end
                M_PRESS: begin
                    if (released) begin
                        n_mode = M_REL;
                    end else begin
                        n_down = r_tick;
                    end
                    if (n_down > i_cfg.hold_ticks) n_mode = M_LSTART;
                end
                M_LSTART: begin
                    ev     = EV_LSTART;
                    n_mode = M_LHELD;
                end
                M_LHELD: begin
                    if (released) begin
                        n_mode = M_REL;
                    end else begin
                        n_down = r_tick;
                    end
                end
                M_REL: begin
                    n_mode = (r_down < i_cfg.click_ticks) ? M_GAP : M_REPORT;
                end
                M_REPORT: begin
                    ev       = (r_down < i_cfg.hold_ticks) ? EV_SINGLE : EV_LEND;
                    n_down   = '0;
                    tick_mid = '0;
                    n_mode   = M_IDLE;
                end
                M_GAP: begin
                    if (released) begin
                        n_down = r_tick;
                        if (r_tick > i_cfg.double_gap_ticks) n_mode = M_REPORT;
                    end else begin
                        n_mode = M_PRESS2;
                    end
                end
                M_PRESS2: begin
                    if (released) begin
                        n_mode = M_DOUBLE;
                    end else begin
                        n_down = r_tick;
                    end
                end
                M_DOUBLE: begin
                    ev       = EV_DOUBLE;
                    n_mode   = M_IDLE;
                    tick_mid = '0;
                end
                default: n_mode = M_IDLE;
            endcase
        end
        // saturating tick count
        n_tick = (tick_mid == '1) ? tick_mid : tick_mid + TICK_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_last <= REL_LVL_RST;
            r_tick <= '0;
            r_down <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_last <= n_last;
            r_tick <= n_tick;
            r_down <= n_down;
        end
    end

    assign o_event = ev;

endmodule

// ===== sv/bcc_checker.sv =====
// port-level checks for the button click classifier, bound to the top level
// depends on bcc_pkg and button_click_classifier_assert.svh
`include "button_click_classifier_assert.svh"

module bcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_event_code
);
    import bcc_pkg::*;

    logic r_prev_evt;
    logic out_fire;

    assign out_fire = o_out_valid && i_out_ready;

    // last delivered beat carried an event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_evt <= 1'b0;
        end else if (out_fire) begin
            r_prev_evt <= (o_event_code != EV_NONE);
        end
    end

    `BCC_ASSERT_NOW(a_code_range, i_clk, i_rst_n, o_out_valid,
        o_event_code == EV_NONE || o_event_code == EV_SINGLE ||
        o_event_code == EV_DOUBLE || o_event_code == EV_LSTART ||
        o_event_code == EV_LEND)
    `BCC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_event_code))
    `BCC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    `BCC_ASSERT_NOW(a_no_back_to_back_evt, i_clk, i_rst_n, out_fire && r_prev_evt,
        o_event_code == EV_NONE)

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_event_code (o_event_code)
);

// ===== dv/button_click_classifier_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for button_click_classifier: pin level beats in, event codes checked
// depends on bcc_pkg and button_click_classifier; keeps its own model of the classifier

module button_click_classifier_tb;
    import bcc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_PRESSED    = 4'd1,
        ST_LONG_START = 4'd2,
        ST_LONG_HELD  = 4'd3,
        ST_RELEASED   = 4'd4,
        ST_REPORT     = 4'd5,
        ST_GAP        = 4'd6,
        ST_PRESS2     = 4'd7,
        ST_DOUBLE     = 4'd8
    } t_mode;

    localparam logic [IDX_W-1:0]  CFG_SPARE_FIRST = 3'd5;
    localparam logic [IDX_W-1:0]  CFG_SPARE_LAST  = 3'd7;
    localparam logic [TICK_W-1:0] TICK_MAX        = 16'hFFFF;
    localparam int MAX_WAIT     = 8;
    localparam int RANDOM_ITEMS = 1600;
    localparam int PHASE_ITEMS  = 220;
    localparam int RUN_CAP      = 40;

    logic              i_clk;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_ready;
    logic              i_button_level = 1'b1;
    logic              o_out_valid;
    logic              i_out_ready    = 1'b0;
    logic [EVT_W-1:0]  o_event_code;
    logic              i_cfg_wr_en    = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx      = CFG_DEBOUNCE;
    logic [TICK_W-1:0] i_cfg_wdata    = '0;

    // classifier model state
    t_cfg              cls_cfg   = {DEBOUNCE_RST, HOLD_RST, CLICK_RST, GAP_RST, REL_LVL_RST};
    t_mode             cls_mode  = ST_IDLE;
    logic              cls_last  = REL_LVL_RST;
    logic [TICK_W-1:0] cls_ticks = '0;
    logic [TICK_W-1:0] cls_down  = '0;

    t_event pending_events[$];
    int     mismatches = 0;
    int     beats_sent = 0;
    bit     no_idle    = 1'b0;

    button_click_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_button_level (i_button_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_code   (o_event_code),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("button_click_classifier_tb: done, errors");
        $finish;
    end

    function automatic t_event step_classifier(input logic lvl);
        t_event ev;
        logic   rel;
        ev = EV_NONE;
        if (lvl != cls_last) begin
            cls_last  = lvl;
            cls_ticks = 16'd1;
        end else if (cls_ticks > cls_cfg.debounce_ticks) begin
            rel = (lvl == cls_cfg.released_level);
            case (cls_mode)
                ST_IDLE: begin
                    if (!rel) cls_mode = ST_PRESSED;
                end
                ST_PRESSED: begin
                    if (rel) cls_mode = ST_RELEASED;
                    else cls_down = cls_ticks;
                    // long press start wins even on a released tick
                    if (cls_down > cls_cfg.hold_ticks) cls_mode = ST_LONG_START;
                end
                ST_LONG_START: begin
                    ev       = EV_LSTART;
                    cls_mode = ST_LONG_HELD;
                end
                ST_LONG_HELD: begin
                    if (rel) cls_mode = ST_RELEASED;
                    else cls_down = cls_ticks;
                end
                ST_RELEASED: begin
                    cls_mode = (cls_down < cls_cfg.click_ticks) ? ST_GAP : ST_REPORT;
                end
                ST_REPORT: begin
                    ev        = (cls_down < cls_cfg.hold_ticks) ? EV_SINGLE : EV_LEND;
                    cls_down  = '0;
                    cls_ticks = '0;
                    cls_mode  = ST_IDLE;
                end
                ST_GAP: begin
                    if (rel) begin
                        cls_down = cls_ticks;
                        if (cls_down > cls_cfg.double_gap_ticks) cls_mode = ST_REPORT;
                    end else begin
                        cls_mode = ST_PRESS2;
                    end
                end
                ST_PRESS2: begin
                    if (rel) cls_mode = ST_DOUBLE;
                    else cls_down = cls_ticks;
                end
                ST_DOUBLE: begin
                    ev        = EV_DOUBLE;
                    cls_mode  = ST_IDLE;
                    cls_ticks = '0;
                end
                default: begin
                    cls_mode = ST_IDLE;
                end
            endcase
        end
        if (cls_ticks != TICK_MAX) cls_ticks = cls_ticks + 1'b1;
        return ev;
    endfunction

    function automatic int capped(input logic [TICK_W-1:0] v);
        return (v > RUN_CAP) ? RUN_CAP : int'(v);
    endfunction

    function automatic logic [TICK_W-1:0] pick_ticks(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return TICK_MAX;
            default: return TICK_W'($urandom_range(lo, hi));
        endcase
    endfunction

    // one pin level beat, valid held until accepted
    task automatic send_beat(input logic lvl);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_button_level <= lvl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_events.push_back(step_classifier(lvl));
        beats_sent++;
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_beat(lvl);
    endtask

    // stop sending and wait for every outstanding beat to come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_DEBOUNCE: cls_cfg.debounce_ticks   = data;
            CFG_HOLD:     cls_cfg.hold_ticks       = data;
            CFG_CLICK:    cls_cfg.click_ticks      = data;
            CFG_GAP:      cls_cfg.double_gap_ticks = data;
            CFG_REL_LVL:  cls_cfg.released_level   = data[0];
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [TICK_W-1:0] deb, input logic [TICK_W-1:0] hold,
                                 input logic [TICK_W-1:0] clk_t, input logic [TICK_W-1:0] gap,
                                 input logic rel);
        drain();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_HOLD, hold);
        write_reg(CFG_CLICK, clk_t);
        write_reg(CFG_GAP, gap);
        // upper bits are don't-care for the polarity register
        write_reg(CFG_REL_LVL, {15'($urandom), rel});
    endtask

    task automatic test_reset_defaults();
        send_run(1'b1, 2);
        send_run(1'b0, 22);
        send_run(1'b1, 2);
    endtask

    task automatic test_click_types();
        write_setting(16'd0, 16'd2, 16'd2, 16'd1, 1'b1);
        // single click, double click, long press
        send_run(1'b0, 2);
        send_run(1'b1, 4);
        send_run(1'b0, 2);
        send_run(1'b1, 1);
        send_run(1'b0, 2);
        send_run(1'b1, 3);
        send_run(1'b0, 5);
        send_run(1'b1, 4);
        // active-high button
        drain();
        write_reg(CFG_REL_LVL, 16'hFFFE);
        send_run(1'b1, 5);
        send_run(1'b0, 4);
    endtask

    task automatic test_register_extremes();
        write_setting(TICK_MAX, 16'd0, TICK_MAX, 16'd0, 1'b0);
        send_run(1'b1, 4);
        send_run(1'b0, 3);
        write_setting(16'd0, TICK_MAX, 16'd0, TICK_MAX, 1'b1);
        send_run(1'b0, 4);
        send_run(1'b1, 5);
        // writes to unused indexes must change nothing
        drain();
        for (int k = CFG_SPARE_FIRST; k <= CFG_SPARE_LAST; k++) begin
            write_reg(k[IDX_W-1:0], '0);
        end
        send_run(1'b0, 3);
        send_run(1'b1, 4);
    endtask

    task automatic test_random_sequences();
        int start;
        int phase_end;
        int deb;
        int hold;
        int clk_t;
        int gap;
        int press_len;
        int gap_len;
        logic rel;
        start = beats_sent;
        while (beats_sent - start < RANDOM_ITEMS) begin
            write_setting(pick_ticks(0, 4), pick_ticks(0, 30), pick_ticks(0, 20),
                          pick_ticks(0, 12), 1'($urandom));
            no_idle   = ($urandom_range(0, 3) == 0);
            deb       = capped(cls_cfg.debounce_ticks);
            hold      = capped(cls_cfg.hold_ticks);
            clk_t     = capped(cls_cfg.click_ticks);
            gap       = capped(cls_cfg.double_gap_ticks);
            rel       = cls_cfg.released_level;
            phase_end = beats_sent + PHASE_ITEMS;
            while (beats_sent < phase_end) begin
                case ($urandom_range(0, 19))
                    0, 1: send_run(1'($urandom), $urandom_range(1, 3));
                    2: drain();
                    default: begin
                        if ($urandom_range(0, 2) == 0)
                            press_len = $urandom_range(deb + hold, deb + hold + 6);
                        else
                            press_len = $urandom_range(1, deb + clk_t + 2);
                        if ($urandom_range(0, 1) == 0)
                            gap_len = $urandom_range(1, deb + gap + 1);
                        else
                            gap_len = $urandom_range(deb + gap + 2, deb + gap + 8);
                        send_run(~rel, press_len);
                        send_run(rel, gap_len);
                    end
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    // result side: random back-pressure and comparison against the model
    initial begin
        t_event want;
        int     stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (pending_events.size() == 0) begin
                $error("event_code: unexpected beat, got %0d", o_event_code);
                mismatches++;
            end else begin
                want = pending_events.pop_front();
                if (o_event_code !== want) begin
                    $error("event_code: expected %0d, got %0d", want, o_event_code);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_click_types();
        test_register_extremes();
        test_random_sequences();
        drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("button_click_classifier_tb: done, clean");
        else
            $display("button_click_classifier_tb: done, errors");
        $finish;
    end

endmodule
